// ----- design/kma_pkg.sv -----
// ----------------------------------------------------------------------------
// kma_pkg: shared types and constants
// Types, widths and command codes for the k-means engine.
// ----------------------------------------------------------------------------
package kma_pkg;

  localparam int unsigned MaxClusters = 16;
  localparam int unsigned MaxDim      = 8;
  localparam int unsigned MaxVectors  = 65536;

  localparam int unsigned ElemW = 16;
  localparam int unsigned DistW = 35;
  localparam int unsigned SumW  = 32;
  localparam int unsigned CntW  = 17;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ASSIGN = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_ASSIGN = 2'd0,
    RES_CHECK  = 2'd1,
    RES_UPDATE = 2'd2,
    RES_NONE   = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    REG_NUM_CLUSTERS = 2'd0,
    REG_DIM_IN_USE   = 2'd1,
    REG_EPS_SQUARED  = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_e;

  // control that the sequencer carries alongside the lane pipeline
  typedef struct packed {
    logic first;
    logic valid;
  } lane_ctl_t;

endpackage

// ----- design/kma_lane.sv -----
// ----------------------------------------------------------------------------
// kma_lane: one dimension lane
// Registered squared difference of one vector element and one centroid element.
// ----------------------------------------------------------------------------
module kma_lane (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [kma_pkg::ElemW-1:0] vec_i,
  input  logic signed [kma_pkg::ElemW-1:0] cen_i,
  output logic [2*kma_pkg::ElemW-1:0]      sq_o
);
  import kma_pkg::*;

  logic signed [ElemW:0] diff;
  logic [ElemW:0] mag;
  logic [2*ElemW-1:0] sq_q;

  assign diff = {vec_i[ElemW-1], vec_i} - {cen_i[ElemW-1], cen_i};
  assign mag  = diff[ElemW] ? (~diff + 1'b1) : diff;

  // |diff| <= 65535, square fits 32 bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= ElemW'(mag) * ElemW'(mag);
    end
  end
  assign sq_o = sq_q;
endmodule

// ----- design/kma_merge.sv -----
// ----------------------------------------------------------------------------
// kma_merge: lane merge
// Sums lane squares over the elements in use, one register stage.
// ----------------------------------------------------------------------------
module kma_merge #(
  parameter int unsigned MaxDim = kma_pkg::MaxDim
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [MaxDim-1:0][2*kma_pkg::ElemW-1:0] sq_i,
  input  logic [3:0]                       dim_i,
  output logic [kma_pkg::DistW-1:0]        dist_o
);
  import kma_pkg::*;

  logic [DistW-1:0] acc;
  logic [DistW-1:0] dist_q;

  always_comb begin
    acc = '0;
    for (int j = 0; j < MaxDim; j++) begin
      if (4'(j) < dim_i) acc = acc + DistW'(sq_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dist_q <= acc;
  end
  assign dist_o = dist_q;
endmodule

// ----- design/kma_divider.sv -----
// ----------------------------------------------------------------------------
// kma_divider: serial divider
// Signed sum over unsigned count, truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module kma_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [kma_pkg::SumW-1:0] num_i,
  input  logic [kma_pkg::CntW-1:0]      den_i,
  output logic                          done_o,
  output logic signed [kma_pkg::ElemW-1:0] quo_o
);
  import kma_pkg::*;

  logic [SumW-1:0] quo_q, quo_d;
  logic [CntW:0]   rem_q, rem_d;
  logic [CntW-1:0] den_q;
  logic            neg_q;
  logic [5:0]      cnt_q;
  logic            busy_q;
  logic [CntW:0]   trial;

  always_comb begin
    trial = {rem_q[CntW-1:0], quo_q[SumW-1]};
    quo_d = {quo_q[SumW-2:0], 1'b0};
    rem_d = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[SumW-1] ? (~num_i + 1'b1) : num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[SumW-1];
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o = neg_q ? ElemW'(~quo_q + 1'b1) : ElemW'(quo_q);
endmodule

// ----- design/kmeans_assign_update.sv -----
// ----------------------------------------------------------------------------
// kmeans_assign_update: Lloyd k-means engine
// Load, assign, update and check commands over a centroid store.
// ----------------------------------------------------------------------------
// Commands enter on start when busy is low; cmd_i picks load, assign,
// update or check. Results appear for one cycle with done_o high; the
// receiver cannot stall, so no result is ever held.
// All dimensions go through parallel lanes; one centroid row is read from
// the centroid memory per cycle. Commands run one at a time: busy stays
// high until the command has fully finished.
// Load: no result.
// Assign: result after the scan of the clusters in use, then the vector
//   is added into the per-cluster sums (sum memory, one read and one
//   write port) element by element, unless the cluster count is full.
// Check: result after the read, lane and merge registers.
// Update: for each cluster in use and element in use one serial divide
//   with its memory access; an empty cluster takes one such pass. Then a
//   clear pass over the MAX_CLUSTERS*MAX_DIM words of the sum memory.
// Reset: the sum memory is cleared word by word first, with busy high;
//   counts are in flip-flops cleared at once. Configuration writes go
//   through cfg_valid_i/cfg_ready_o; keeping them between commands is up
//   to the user, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module kmeans_assign_update #(
  parameter int unsigned MaxClusters = kma_pkg::MaxClusters,
  parameter int unsigned MaxDim      = kma_pkg::MaxDim,
  parameter int unsigned MaxVectors  = kma_pkg::MaxVectors
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd_i,
  input  logic [3:0]                  centroid_index_i,
  input  logic signed [15:0]          element_0_i,
  input  logic signed [15:0]          element_1_i,
  input  logic signed [15:0]          element_2_i,
  input  logic signed [15:0]          element_3_i,
  input  logic signed [15:0]          element_4_i,
  input  logic signed [15:0]          element_5_i,
  input  logic signed [15:0]          element_6_i,
  input  logic signed [15:0]          element_7_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [kma_pkg::DistW-1:0]   cfg_data_i,
  output logic                        done_o,
  output logic [1:0]                  result_kind_o,
  output logic [3:0]                  cluster_o,
  output logic [kma_pkg::DistW-1:0]   distance_o,
  output logic                        converged_o
);
  import kma_pkg::*;

  localparam int unsigned CIdxW = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int unsigned DIdxW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned AddrW = CIdxW + DIdxW;
  localparam int unsigned Depth = MaxClusters * MaxDim;
  localparam int unsigned KW    = $clog2(MaxClusters + 1);
  localparam int unsigned DW    = $clog2(MaxDim + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_ACC_RD, ST_ACC_WR,
    ST_UPD_RD, ST_UPD_GO, ST_UPD_DIV, ST_UPD_WR, ST_SWEEP
  } state_e;

  state_e state_q;

  // configuration
  logic [4:0]       num_clusters_q;
  logic [3:0]       dim_in_use_q;
  logic [DistW-1:0] eps_q;
  logic [KW-1:0]    k_eff;
  logic [DW-1:0]    d_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q <= 5'd2;
      dim_in_use_q   <= 4'd8;
      eps_q          <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_NUM_CLUSTERS: num_clusters_q <= cfg_data_i[4:0];
        REG_DIM_IN_USE:   dim_in_use_q   <= cfg_data_i[3:0];
        REG_EPS_SQUARED:  eps_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_clusters_q == 5'd0) k_eff = KW'(1);
    else if (32'(num_clusters_q) > MaxClusters) k_eff = KW'(MaxClusters);
    else k_eff = KW'(num_clusters_q);
    if (dim_in_use_q == 4'd0) d_eff = DW'(1);
    else if (32'(dim_in_use_q) > MaxDim) d_eff = DW'(MaxDim);
    else d_eff = DW'(dim_in_use_q);
  end

  // input vector latch
  logic signed [15:0] in_vec [8];
  logic [MaxDim-1:0][ElemW-1:0] vec_q;
  logic [1:0] cmd_q;
  logic [3:0] idx_q;

  assign in_vec[0] = element_0_i;
  assign in_vec[1] = element_1_i;
  assign in_vec[2] = element_2_i;
  assign in_vec[3] = element_3_i;
  assign in_vec[4] = element_4_i;
  assign in_vec[5] = element_5_i;
  assign in_vec[6] = element_6_i;
  assign in_vec[7] = element_7_i;

  // centroid memory: one row per word
  logic [MaxDim-1:0][ElemW-1:0] cen_mem [MaxClusters];
  logic [MaxDim-1:0][ElemW-1:0] cen_rd_q;
  logic [CIdxW-1:0] cen_raddr;
  logic             cen_we;
  logic [CIdxW-1:0] cen_waddr;
  logic [MaxDim-1:0][ElemW-1:0] cen_wdata;

  always_ff @(posedge clk_i) begin
    if (cen_we) cen_mem[cen_waddr] <= cen_wdata;
    cen_rd_q <= cen_mem[cen_raddr];
  end

  // sum memory: one element per word
  logic [SumW-1:0] sum_mem [Depth];
  logic [SumW-1:0] sum_rd_q;
  logic [AddrW-1:0] sum_raddr, sum_waddr;
  logic             sum_we;
  logic [SumW-1:0]  sum_wdata;

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rd_q <= sum_mem[sum_raddr];
  end

  logic [CntW-1:0] count_q [MaxClusters];

  // lanes and merge
  logic [MaxDim-1:0][2*ElemW-1:0] sq;
  logic [DistW-1:0] merge_dist;
  lane_ctl_t ctl_q [3];

  for (genvar j = 0; j < MaxDim; j++) begin : g_lane
    kma_lane u_lane (
      .clk_i (clk_i),
      .en_i  (1'b1),
      .vec_i (vec_q[j]),
      .cen_i (cen_rd_q[j]),
      .sq_o  (sq[j])
    );
  end

  kma_merge #(.MaxDim(MaxDim)) u_merge (
    .clk_i  (clk_i),
    .en_i   (1'b1),
    .sq_i   (sq),
    .dim_i  (4'(d_eff)),
    .dist_o (merge_dist)
  );

  // divider
  logic             div_start;
  logic             div_done;
  logic signed [ElemW-1:0] div_quo;
  logic [CIdxW-1:0] upd_i_q;
  logic [DIdxW-1:0] upd_j_q;

  kma_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_rd_q),
    .den_i   (count_q[upd_i_q]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer
  logic [CIdxW:0]   scan_q;        // rows issued
  logic [CIdxW-1:0] tag_q [3];     // row tags through read, lane, merge
  logic [DistW-1:0] best_d_q;
  logic [CIdxW-1:0] best_q;
  logic [DIdxW:0]   acc_j_q;
  logic [AddrW:0]   sweep_q;
  logic [MaxDim-1:0][ElemW-1:0] upd_row_q;
  logic             accept;
  logic             upd_en;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign upd_en = (count_q[upd_i_q] != '0);

  always_comb begin
    cen_raddr = CIdxW'(scan_q);
    if (state_q == ST_UPD_RD || state_q == ST_UPD_GO || state_q == ST_UPD_DIV ||
        state_q == ST_UPD_WR)
      cen_raddr = upd_i_q;
    else if (accept) cen_raddr = CIdxW'(centroid_index_i);
    cen_we    = accept && (cmd_e'(cmd_i) == CMD_LOAD) && (32'(centroid_index_i) < MaxClusters);
    cen_waddr = CIdxW'(centroid_index_i);
    for (int j = 0; j < MaxDim; j++) cen_wdata[j] = in_vec[j];
    if (state_q == ST_UPD_WR) begin
      cen_we    = upd_en;
      cen_waddr = upd_i_q;
      cen_wdata = upd_row_q;
    end
    sum_raddr = {best_q, DIdxW'(acc_j_q)};
    if (state_q == ST_UPD_RD || state_q == ST_UPD_GO) sum_raddr = {upd_i_q, upd_j_q};
    sum_we    = 1'b0;
    sum_waddr = {best_q, DIdxW'(acc_j_q)};
    sum_wdata = sum_rd_q + SumW'($signed(vec_q[DIdxW'(acc_j_q)]));
    if (state_q == ST_ACC_WR) sum_we = 1'b1;
    if (state_q == ST_CLEAR || state_q == ST_SWEEP) begin
      sum_we    = 1'b1;
      sum_waddr = AddrW'(sweep_q);
      sum_wdata = '0;
    end
    // sum word read in ST_UPD_RD is registered by now
    div_start = (state_q == ST_UPD_GO);
  end

  logic [CIdxW-1:0] new_best;
  logic             take_new;
  assign take_new = ctl_q[2].valid && (ctl_q[2].first || merge_dist < best_d_q);
  assign new_best = tag_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      scan_q      <= '0;
      done_o      <= 1'b0;
      for (int i = 0; i < 3; i++) ctl_q[i] <= '0;
      for (int i = 0; i < MaxClusters; i++) count_q[i] <= '0;
    end else begin
      done_o <= 1'b0;
      ctl_q[1] <= ctl_q[0];
      ctl_q[2] <= ctl_q[1];
      ctl_q[0] <= '0;
      tag_q[1] <= tag_q[0];
      tag_q[2] <= tag_q[1];
      if (take_new) begin
        best_d_q <= merge_dist;
        best_q   <= new_best;
      end
      case (state_q)
        ST_CLEAR, ST_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (32'(sweep_q) == Depth - 1) begin
            sweep_q <= '0;
            if (state_q == ST_SWEEP) begin
              for (int i = 0; i < MaxClusters; i++) count_q[i] <= '0;
              done_o        <= 1'b1;
              result_kind_o <= RES_UPDATE;
              cluster_o     <= '0;
              distance_o    <= '0;
              converged_o   <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            for (int j = 0; j < MaxDim; j++) vec_q[j] <= in_vec[j];
            cmd_q <= cmd_i;
            idx_q <= centroid_index_i;
            case (cmd_e'(cmd_i))
              CMD_LOAD: ;
              CMD_ASSIGN: begin
                // row 0 read is issued below via scan_q
                scan_q  <= '0;
                state_q <= ST_SCAN;
              end
              CMD_CHECK: begin
                if (32'(centroid_index_i) < MaxClusters) begin
                  ctl_q[0] <= '{first: 1'b1, valid: 1'b1};
                  tag_q[0] <= CIdxW'(centroid_index_i);
                  state_q  <= ST_DRAIN;
                end else begin
                  done_o        <= 1'b1;
                  result_kind_o <= RES_CHECK;
                  cluster_o     <= centroid_index_i;
                  distance_o    <= '0;
                  converged_o   <= 1'b0;
                end
              end
              CMD_UPDATE: begin
                upd_i_q <= '0;
                upd_j_q <= '0;
                state_q <= ST_UPD_RD;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // read of row scan_q is registered this edge
          ctl_q[0] <= '{first: (scan_q == '0), valid: 1'b1};
          tag_q[0] <= CIdxW'(scan_q);
          scan_q   <= scan_q + 1'b1;
          if (KW'(scan_q) == k_eff - 1'b1) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (ctl_q[2].valid && !ctl_q[1].valid && !ctl_q[0].valid) begin
            if (cmd_e'(cmd_q) == CMD_CHECK) begin
              done_o        <= 1'b1;
              result_kind_o <= RES_CHECK;
              cluster_o     <= idx_q;
              distance_o    <= merge_dist;
              converged_o   <= merge_dist < eps_q;
              state_q       <= ST_IDLE;
            end else begin
              done_o        <= 1'b1;
              result_kind_o <= RES_ASSIGN;
              cluster_o     <= 4'(take_new ? new_best : best_q);
              distance_o    <= take_new ? merge_dist : best_d_q;
              converged_o   <= 1'b0;
              acc_j_q       <= '0;
              state_q       <= ST_ACC_RD;
            end
          end
        end
        ST_ACC_RD: begin
          if (32'(count_q[best_q]) >= MaxVectors) state_q <= ST_IDLE;
          else state_q <= ST_ACC_WR;
        end
        ST_ACC_WR: begin
          acc_j_q <= acc_j_q + 1'b1;
          if (DW'(acc_j_q) == d_eff - 1'b1) begin
            count_q[best_q] <= count_q[best_q] + 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_ACC_RD;
          end
        end
        ST_UPD_RD: begin
          state_q <= ST_UPD_GO;
        end
        ST_UPD_GO: begin
          state_q <= ST_UPD_DIV;
        end
        ST_UPD_DIV: begin
          if (div_done) begin
            for (int j = 0; j < MaxDim; j++) begin
              upd_row_q[j] <= (DIdxW'(j) == upd_j_q) ? div_quo : cen_rd_q[j];
            end
            state_q <= ST_UPD_WR;
          end
        end
        ST_UPD_WR: begin
          state_q <= ST_UPD_RD;
          if (DW'(upd_j_q) == d_eff - 1'b1 || !upd_en) begin
            upd_j_q <= '0;
            if (KW'(upd_i_q) == k_eff - 1'b1) state_q <= ST_SWEEP;
            else upd_i_q <= upd_i_q + 1'b1;
          end else begin
            upd_j_q <= upd_j_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // assertions
  a_no_done_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_e'(cmd_i) == CMD_LOAD |=> !done_o)
    else $error("result after load");

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_e'(cmd_i) == CMD_ASSIGN |=> busy)
    else $error("assign did not hold busy");

  a_update_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_kind_o == RES_UPDATE |-> distance_o == '0 && !converged_o)
    else $error("update result fields not clear");

endmodule

// ----- tb/tb_kmeans_assign_update.sv -----
// ----------------------------------------------------------------------------
// tb_kmeans_assign_update: testbench for the k-means engine
// Drives load, assign, update and check commands with random gaps, keeps
// its own copy of centroids, sums and counts, and checks every result
// word against the predicted one.
// ----------------------------------------------------------------------------
module tb_kmeans_assign_update;
  import kma_pkg::*;

  typedef struct {
    res_e              kind;
    logic [3:0]        cluster;
    logic [DistW-1:0]  dist_val;
    logic              conv;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd_i = CMD_LOAD;
  logic [3:0] centroid_index_i = '0;
  logic signed [15:0] elem_q [MaxDim];
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = REG_NUM_CLUSTERS;
  logic [DistW-1:0] cfg_data_i = '0;
  logic done_o;
  logic [1:0] result_kind_o;
  logic [3:0] cluster_o;
  logic [DistW-1:0] distance_o;
  logic converged_o;

  // predictor state
  logic signed [15:0] centroid_m [MaxClusters][MaxDim];
  longint             sum_m [MaxClusters][MaxDim];
  int                 count_m [MaxClusters];
  logic [4:0]         k_reg = 5'd2;
  logic [3:0]         dim_reg = 4'd8;
  logic [DistW-1:0]   eps_reg = '0;

  result_t expected_q [$];
  int errors = 0;

  initial for (int j = 0; j < MaxDim; j++) elem_q[j] = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  kmeans_assign_update u_top (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .centroid_index_i,
    .element_0_i(elem_q[0]), .element_1_i(elem_q[1]),
    .element_2_i(elem_q[2]), .element_3_i(elem_q[3]),
    .element_4_i(elem_q[4]), .element_5_i(elem_q[5]),
    .element_6_i(elem_q[6]), .element_7_i(elem_q[7]),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .result_kind_o, .cluster_o, .distance_o, .converged_o
  );

  function automatic int eff_k();
    if (k_reg < 1) return 1;
    if (k_reg > MaxClusters) return MaxClusters;
    return k_reg;
  endfunction

  function automatic int eff_dim();
    if (dim_reg < 1) return 1;
    if (dim_reg > MaxDim) return MaxDim;
    return dim_reg;
  endfunction

  function automatic longint sq_distance(int row);
    longint acc;
    longint diff;
    acc = 0;
    for (int j = 0; j < eff_dim(); j++) begin
      diff = longint'(elem_q[j]) - longint'(centroid_m[row][j]);
      acc += diff * diff;
    end
    return acc;
  endfunction

  // work out the result of the command just accepted
  function automatic void predict_command(cmd_e cmd, int idx);
    result_t r;
    longint d;
    longint best_d;
    int best;
    longint mean;
    r.kind = RES_ASSIGN; r.cluster = '0; r.dist_val = '0; r.conv = 1'b0;
    case (cmd)
      CMD_LOAD: begin
        for (int j = 0; j < MaxDim; j++) centroid_m[idx][j] = elem_q[j];
        return;
      end
      CMD_ASSIGN: begin
        best = 0;
        best_d = sq_distance(0);
        for (int i = 1; i < eff_k(); i++) begin
          d = sq_distance(i);
          if (d < best_d) begin
            best_d = d;
            best = i;
          end
        end
        if (count_m[best] < MaxVectors) begin
          count_m[best]++;
          for (int j = 0; j < eff_dim(); j++) sum_m[best][j] += longint'(elem_q[j]);
        end
        r.cluster = 4'(best);
        r.dist_val = best_d[DistW-1:0];
      end
      CMD_UPDATE: begin
        for (int i = 0; i < eff_k(); i++) begin
          if (count_m[i] != 0) begin
            for (int j = 0; j < eff_dim(); j++) begin
              mean = sum_m[i][j] / count_m[i];
              centroid_m[i][j] = mean[15:0];
            end
          end
        end
        for (int i = 0; i < MaxClusters; i++) begin
          count_m[i] = 0;
          for (int j = 0; j < MaxDim; j++) sum_m[i][j] = 0;
        end
        r.kind = RES_UPDATE;
      end
      default: begin
        d = sq_distance(idx);
        r.kind = RES_CHECK;
        r.cluster = 4'(idx);
        r.dist_val = d[DistW-1:0];
        r.conv = (d < longint'(eps_reg));
      end
    endcase
    expected_q.push_back(r);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: kind %0d", result_kind_o);
        errors++;
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (result_kind_o !== e.kind) begin
          $error("result_kind: expected %0d, got %0d", e.kind, result_kind_o);
          errors++;
        end
        if (cluster_o !== e.cluster) begin
          $error("cluster: expected %0d, got %0d", e.cluster, cluster_o);
          errors++;
        end
        if (distance_o !== e.dist_val) begin
          $error("distance: expected %0d, got %0d", e.dist_val, distance_o);
          errors++;
        end
        if (converged_o !== e.conv) begin
          $error("converged: expected %0d, got %0d", e.conv, converged_o);
          errors++;
        end
      end
    end
  end

  // send one command word after a gap of idle cycles
  task automatic send_word(cmd_e cmd, int idx, logic signed [15:0] v [MaxDim], int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    cmd_i = cmd;
    centroid_index_i = 4'(idx);
    for (int j = 0; j < MaxDim; j++) elem_q[j] = v[j];
    do @(posedge clk_i); while (busy);
    predict_command(cmd, idx);
  endtask

  task automatic send_rand_gap(cmd_e cmd, int idx, logic signed [15:0] v [MaxDim]);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    send_word(cmd, idx, v, gap);
  endtask

  // drain all expected results and let trailing work finish
  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [DistW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_NUM_CLUSTERS: k_reg = data[4:0];
      REG_DIM_IN_USE:   dim_reg = data[3:0];
      REG_EPS_SQUARED:  eps_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_elem();
    if ($urandom_range(0, 1)) return 16'($urandom());
    return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
  endfunction

  task automatic test_load_all();
    logic signed [15:0] v [MaxDim];
    for (int i = 0; i < MaxClusters; i++) begin
      for (int j = 0; j < MaxDim; j++) v[j] = rand_elem();
      send_rand_gap(CMD_LOAD, i, v);
    end
  endtask

  task automatic test_extremes();
    logic signed [15:0] v [MaxDim];
    for (int j = 0; j < MaxDim; j++) v[j] = 16'sh8000;
    send_word(CMD_LOAD, 0, v, 0);
    for (int j = 0; j < MaxDim; j++) v[j] = 16'sh7fff;
    send_word(CMD_LOAD, 1, v, 0);
    send_word(CMD_CHECK, 0, v, 0);
    send_word(CMD_ASSIGN, 0, v, 2);
    for (int j = 0; j < MaxDim; j++) v[j] = 16'sh8000;
    send_word(CMD_ASSIGN, 0, v, 0);
    send_word(CMD_UPDATE, 0, v, 0);
  endtask

  // equal rows: the lower cluster number wins
  task automatic test_tie();
    logic signed [15:0] v [MaxDim];
    for (int j = 0; j < MaxDim; j++) v[j] = 16'sd256;
    send_word(CMD_LOAD, 0, v, 0);
    send_word(CMD_LOAD, 1, v, 0);
    for (int j = 0; j < MaxDim; j++) v[j] = -16'sd100;
    send_word(CMD_ASSIGN, 0, v, 0);
    send_word(CMD_UPDATE, 0, v, 1);
    send_word(CMD_CHECK, 1, v, 0);
  endtask

  // update with no assigns keeps every centroid
  task automatic test_empty_update();
    logic signed [15:0] v [MaxDim];
    for (int j = 0; j < MaxDim; j++) v[j] = rand_elem();
    send_word(CMD_UPDATE, 0, v, 0);
    send_word(CMD_CHECK, 0, v, 0);
    send_word(CMD_CHECK, 15, v, 3);
  endtask

  task automatic test_random_phase(int n);
    logic signed [15:0] v [MaxDim];
    int r;
    for (int t = 0; t < n; t++) begin
      for (int j = 0; j < MaxDim; j++) v[j] = rand_elem();
      r = $urandom_range(0, 99);
      if (r < 8) send_rand_gap(CMD_LOAD, $urandom_range(0, 15), v);
      else if (r < 72) send_rand_gap(CMD_ASSIGN, $urandom_range(0, 15), v);
      else if (r < 78) send_rand_gap(CMD_UPDATE, $urandom_range(0, 15), v);
      else send_rand_gap(CMD_CHECK, $urandom_range(0, 15), v);
    end
  endtask

  task automatic test_config_sweep();
    logic [DistW-1:0] eps_rand;
    write_reg(REG_NUM_CLUSTERS, 35'd31);
    write_reg(REG_DIM_IN_USE, 35'd15);
    write_reg(REG_EPS_SQUARED, {DistW{1'b1}});
    test_random_phase(110);
    wait_idle();
    write_reg(REG_NUM_CLUSTERS, 35'd0);
    write_reg(REG_DIM_IN_USE, 35'd0);
    write_reg(REG_EPS_SQUARED, 35'd0);
    test_random_phase(80);
    wait_idle();
    write_reg(REG_NUM_CLUSTERS, 35'd16);
    write_reg(REG_DIM_IN_USE, 35'd1);
    write_reg(REG_EPS_SQUARED, 35'd2000000);
    test_random_phase(110);
    wait_idle();
    write_reg(REG_NUM_CLUSTERS, 35'd1);
    write_reg(REG_DIM_IN_USE, 35'd8);
    eps_rand = DistW'({$urandom(), $urandom()});
    write_reg(REG_EPS_SQUARED, eps_rand);
    test_random_phase(60);
    wait_idle();
    write_reg(REG_NUM_CLUSTERS, 35'($urandom_range(2, 15)) | 35'h7ffffffe0);
    write_reg(REG_DIM_IN_USE, 35'($urandom_range(2, 7)) | 35'h7fffffff0);
    write_reg(REG_EPS_SQUARED, 35'($urandom_range(0, 32'h3fffffff)));
    test_random_phase(150);
  endtask

  initial begin
    for (int i = 0; i < MaxClusters; i++) begin
      count_m[i] = 0;
      for (int j = 0; j < MaxDim; j++) begin
        centroid_m[i][j] = '0;
        sum_m[i][j] = 0;
      end
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_load_all();
    test_extremes();
    test_tie();
    test_empty_update();
    wait_idle();
    test_config_sweep();
    wait_idle();
    if (errors == 0) begin
      $display("tb_kmeans_assign_update: PASS");
    end else begin
      $display("tb_kmeans_assign_update: FAIL");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("tb_kmeans_assign_update: FAIL");
    $finish;
  end

endmodule
